// File: design/i2ct_pkg.sv
// Shared types, constants and decode helpers for the I2C timing calculator.
`default_nettype none
package i2ct_pkg;

   localparam logic [31:0] HSE_HZ       = 32'd8000000;
   localparam logic [31:0] HSI_HZ       = 32'd16000000;
   localparam logic [19:0] SM_LIMIT_HZ  = 20'd100000;
   localparam logic [31:0] SM_RISE_FREQ = 32'd1000000;
   localparam logic [31:0] FM_RISE_FREQ = 32'd3333333;

   // reciprocals for constant divides: q = (x * RECIP) >> SHIFT, exact over the input range
   // x / 1000000 taken as (x >> 6) / 15625 on a 26-bit value
   localparam logic [31:0] MHZ_RECIP     = 32'd70368745;
   localparam logic [5:0]  MHZ_SHIFT     = 6'd40;
   // x / 3333333 on a 32-bit value
   localparam logic [31:0] FM_RISE_RECIP = 32'd2702160047;
   localparam logic [5:0]  FM_RISE_SHIFT = 6'd53;
   // x / 3 on a 32-bit value
   localparam logic [31:0] DIV3_RECIP    = 32'hAAAA_AAAB;
   localparam logic [5:0]  DIV3_SHIFT    = 6'd33;

   localparam logic [1:0] SEL_HSI = 2'd0;
   localparam logic [1:0] SEL_HSE = 2'd1;

   typedef struct packed {
      logic [31:0] clock_cfg_word;
      logic [31:0] pll_cfg_word;
      logic [19:0] bus_speed_hz;
      logic        duty_16_9;
   } req_type;

   typedef struct packed {
      logic [31:0] pclk1_hz;
      logic [5:0]  freq_field_mhz;
      logic [5:0]  rise_time_value;
      logic [11:0] ccr_divider;
      logic        fast_mode;
      logic        calc_error;
   } rsp_type;

   // decoded request handed from front to back
   typedef struct packed {
      logic        sel_pll;
      logic [31:0] sys_fixed;
      logic [31:0] pll_src;
      logic [5:0]  pll_m;
      logic [8:0]  pll_n;
      logic [3:0]  pll_p;
      logic [3:0]  presc_shift;
      logic        fast;
      logic        ccr_skip;
      logic [31:0] ccr_div;
      logic        err;
   } job_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_DIV_M,
      BK_MUL,
      BK_DIV_P,
      BK_SCALE,
      BK_DIV_MHZ,
      BK_DIV_RISE,
      BK_DIV_CCR,
      BK_OUT
   } back_state_type;

   function automatic logic [3:0] ahb_shift(input logic [3:0] code);
      logic [3:0] s;
      case (code)
         4'd8:    s = 4'd1;
         4'd9:    s = 4'd2;
         4'd10:   s = 4'd3;
         4'd11:   s = 4'd4;
         4'd12:   s = 4'd6;
         4'd13:   s = 4'd7;
         4'd14:   s = 4'd8;
         4'd15:   s = 4'd9;
         default: s = 4'd0;
      endcase
      return s;
   endfunction

   function automatic logic [3:0] apb_shift(input logic [2:0] code);
      logic [3:0] s;
      case (code)
         3'd4:    s = 4'd1;
         3'd5:    s = 4'd2;
         3'd6:    s = 4'd3;
         3'd7:    s = 4'd4;
         default: s = 4'd0;
      endcase
      return s;
   endfunction

   function automatic logic [3:0] pllp_div(input logic [1:0] code);
      logic [3:0] d;
      case (code)
         2'd0:    d = 4'd2;
         2'd1:    d = 4'd4;
         2'd2:    d = 4'd6;
         default: d = 4'd8;
      endcase
      return d;
   endfunction

endpackage
`default_nettype wire

// File: design/i2ct_front.sv
// Front stage: decodes a request into a job and registers it.
`default_nettype none
module i2ct_front (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  i2ct_pkg::req_type       req_data,
   output logic                    job_valid,
   input  wire                     job_ready,
   output i2ct_pkg::job_type       job_data
);
   import i2ct_pkg::*;

   logic    valid_ff, valid_in;
   job_type job_ff, job_in;
   logic [31:0] spd;
   logic [1:0]  sel;

   always_comb begin
      sel = req_data.clock_cfg_word[3:2];
      spd = {12'd0, req_data.bus_speed_hz};
      job_in.sel_pll   = sel[1];
      job_in.sys_fixed = (sel == SEL_HSE) ? HSE_HZ : HSI_HZ;
      job_in.pll_src   = req_data.pll_cfg_word[22] ? HSE_HZ : HSI_HZ;
      job_in.pll_m     = req_data.pll_cfg_word[5:0];
      job_in.pll_n     = req_data.pll_cfg_word[14:6];
      job_in.pll_p     = pllp_div(req_data.pll_cfg_word[17:16]);
      job_in.presc_shift = ahb_shift(req_data.clock_cfg_word[7:4])
                         + apb_shift(req_data.clock_cfg_word[12:10]);
      job_in.fast      = req_data.bus_speed_hz > SM_LIMIT_HZ;
      job_in.ccr_skip  = req_data.bus_speed_hz == 20'd0;
      if (!job_in.fast) begin
         job_in.ccr_div = spd << 1;
      end else if (req_data.duty_16_9) begin
         job_in.ccr_div = (spd << 4) + (spd << 3) + spd;
      end else begin
         job_in.ccr_div = (spd << 1) + spd;
      end
      job_in.err = (job_in.pll_m == 6'd0) || job_in.ccr_skip;
   end

   assign req_ready = !valid_ff || job_ready;
   assign job_valid = valid_ff;
   assign job_data  = job_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req_ready) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_valid && req_ready) begin
         job_ff <= job_in;
      end
   end

endmodule
`default_nettype wire

// File: design/i2ct_queue.sv
// Two-entry job queue between front and back.
`default_nettype none
module i2ct_queue (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     in_valid,
   output logic                    in_ready,
   input  i2ct_pkg::job_type       in_data,
   output logic                    out_valid,
   input  wire                     out_ready,
   output i2ct_pkg::job_type       out_data
);
   import i2ct_pkg::*;

   job_type    mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_ready  = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule
`default_nettype wire

// File: design/i2ct_div.sv
// Radix-2 restoring divider, 32-bit quotient in 32 steps.
`default_nettype none
module i2ct_div (
   input  wire          clock,
   input  wire          reset,
   input  wire          start,
   input  wire  [31:0]  dividend,
   input  wire  [31:0]  divisor,
   output logic         done,
   output logic [31:0]  quotient
);
   logic [31:0] rem_ff, rem_in, quo_ff, quo_in, dsr_ff;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [32:0] sh;

   always_comb begin
      sh      = {rem_ff, quo_ff[31]};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = 32'd0;
         quo_in  = dividend;
         cnt_in  = 5'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (sh >= {1'b0, dsr_ff}) begin
            rem_in = 32'(sh - {1'b0, dsr_ff});
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = sh[31:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (start) begin
         dsr_ff <= divisor;
      end
   end

endmodule
`default_nettype wire

// File: design/i2ct_back.sv
// Back end: sequences the clock derivation and divisions, holds the response register.
`default_nettype none
module i2ct_back (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     job_valid,
   output logic                    job_ready,
   input  i2ct_pkg::job_type       job_data,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output i2ct_pkg::rsp_type       rsp_data
);
   import i2ct_pkg::*;

   back_state_type state_ff, state_in;
   job_type        job_ff;
   logic [31:0]    t_ff, t_in, pclk_ff, pclk_in;
   logic [5:0]     mhz_ff, mhz_in, rise_ff, rise_in;
   logic [11:0]    ccr_ff, ccr_in;
   logic           launched_ff, launched_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff, rsp_in;
   logic           div_start, div_done;
   logic [31:0]    div_dvd, div_dsr, div_q, rise_sum;
   logic [31:0]    mul_a, mul_b, recip_q;
   logic [5:0]     mul_sh;
   logic [63:0]    prod;

   i2ct_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dsr),
      .done     (div_done),
      .quotient (div_q)
   );

   // constant divides by reciprocal multiply
   always_comb begin
      mul_a  = {6'd0, pclk_ff[31:6]};
      mul_b  = MHZ_RECIP;
      mul_sh = MHZ_SHIFT;
      if (state_ff == BK_DIV_P) begin
         mul_a  = {1'b0, t_ff[31:1]};
         mul_b  = DIV3_RECIP;
         mul_sh = DIV3_SHIFT;
      end else if (state_ff == BK_DIV_RISE && job_ff.fast) begin
         mul_a  = pclk_ff;
         mul_b  = FM_RISE_RECIP;
         mul_sh = FM_RISE_SHIFT;
      end
      prod    = {32'd0, mul_a} * {32'd0, mul_b};
      recip_q = 32'(prod >> mul_sh);
   end

   always_comb begin
      state_in     = state_ff;
      t_in         = t_ff;
      pclk_in      = pclk_ff;
      mhz_in       = mhz_ff;
      rise_in      = rise_ff;
      ccr_in       = ccr_ff;
      launched_in  = launched_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      job_ready    = 1'b0;
      div_start    = 1'b0;
      div_dvd      = pclk_ff;
      div_dsr      = job_ff.ccr_div;
      rise_sum     = recip_q + 32'd1;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         BK_IDLE: begin
            job_ready = 1'b1;
            if (job_valid) begin
               if (!job_data.sel_pll) begin
                  t_in     = job_data.sys_fixed;
                  state_in = BK_SCALE;
               end else if (job_data.pll_m == 6'd0) begin
                  t_in     = 32'd0;
                  state_in = BK_SCALE;
               end else begin
                  state_in = BK_DIV_M;
               end
            end
         end
         BK_DIV_M: begin
            div_dvd = job_ff.pll_src;
            div_dsr = {26'd0, job_ff.pll_m};
         end
         BK_MUL: begin
            t_in     = 32'(t_ff * {23'd0, job_ff.pll_n});
            state_in = BK_DIV_P;
         end
         BK_DIV_P: begin
            case (job_ff.pll_p)
               4'd2:    t_in = t_ff >> 1;
               4'd4:    t_in = t_ff >> 2;
               4'd6:    t_in = recip_q;
               default: t_in = t_ff >> 3;
            endcase
            state_in = BK_SCALE;
         end
         BK_SCALE: begin
            pclk_in  = t_ff >> job_ff.presc_shift;
            state_in = BK_DIV_MHZ;
         end
         BK_DIV_MHZ: begin
            mhz_in   = recip_q[5:0];
            state_in = BK_DIV_RISE;
         end
         BK_DIV_RISE: begin
            rise_in = rise_sum[5:0];
            if (job_ff.ccr_skip) begin
               ccr_in   = 12'd0;
               state_in = BK_OUT;
            end else begin
               state_in = BK_DIV_CCR;
            end
         end
         BK_DIV_CCR: begin
            div_dsr = job_ff.ccr_div;
         end
         BK_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in           = 1'b1;
               rsp_in.pclk1_hz        = pclk_ff;
               rsp_in.freq_field_mhz  = mhz_ff;
               rsp_in.rise_time_value = rise_ff;
               rsp_in.ccr_divider     = ccr_ff;
               rsp_in.fast_mode       = job_ff.fast;
               rsp_in.calc_error      = job_ff.err;
               state_in               = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
      // shared divider launch and completion
      if (state_ff == BK_DIV_M || state_ff == BK_DIV_CCR) begin
         if (!launched_ff) begin
            div_start   = 1'b1;
            launched_in = 1'b1;
         end else if (div_done) begin
            launched_in = 1'b0;
            unique case (state_ff)
               BK_DIV_M: begin
                  t_in     = div_q;
                  state_in = BK_MUL;
               end
               default: begin
                  ccr_in   = div_q[11:0];
                  state_in = BK_OUT;
               end
            endcase
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         launched_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         launched_ff  <= launched_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (job_valid && job_ready) begin
         job_ff <= job_data;
      end
      t_ff    <= t_in;
      pclk_ff <= pclk_in;
      mhz_ff  <= mhz_in;
      rise_ff <= rise_in;
      ccr_ff  <= ccr_in;
      rsp_ff  <= rsp_in;
   end

endmodule
`default_nettype wire

// File: design/i2c_timing_from_clock_tree_top.sv
// Top level of the I2C timing calculator: front, queue and back joined.
//
// Usage:
//  - req_* carries one request: clock config word, PLL config word, bus speed
//    and duty select. It is taken when req_valid and req_ready are both high.
//  - rsp_* returns one response per request, in order: APB1 clock, MHz field,
//    rise-time value, CCR divider, fast-mode bit and error flag.
//  - The front registers the decoded request; a two-entry queue feeds the back.
//  - The back runs one 32-step radix-2 divider for src/M and pclk/(k*speed);
//    /P, pclk/1MHz and pclk/rise freq are shifts or reciprocal multiplies.
//    A zero bus speed skips the CCR pass. The back works on one request at a
//    time, and that back occupancy sets the sustained throughput.
//  - From accept to rsp_valid a request passes the front register, the queue
//    and the back's steps.
//  - The front keeps taking requests while the back works, until the front
//    register and queue are full (three requests waiting, a fourth in the back
//    and a fifth held in the response register).
//  - If the receiver stalls, the response register holds; the back finishes
//    its next request and waits for the register to free up.
//  - Synchronous reset empties all stages; no response is pending afterward.
`default_nettype none
module i2c_timing_from_clock_tree_top (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  i2ct_pkg::req_type       req_data,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output i2ct_pkg::rsp_type       rsp_data
);
   import i2ct_pkg::*;

   logic    f_valid, f_ready, q_valid, q_ready;
   job_type f_job, q_job;

   i2ct_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .job_valid (f_valid),
      .job_ready (f_ready),
      .job_data  (f_job)
   );

   i2ct_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   (f_job),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_job)
   );

   i2ct_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (q_valid),
      .job_ready (q_ready),
      .job_data  (q_job),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// File: tb/sv/i2c_timing_from_clock_tree_top_test.sv
// Testbench for the I2C timing calculator: directed and random requests, in-order checking.
`timescale 1ns / 1ps
`default_nettype none
module i2c_timing_from_clock_tree_top_test;
   import i2ct_pkg::*;

   // clock source codes beyond the package's fixed ones
   localparam logic [1:0] SEL_PLL_A = 2'd2;
   localparam logic [1:0] SEL_PLL_B = 2'd3;
   localparam int unsigned N_RANDOM = 1250;
   // worst case covers the back's work per request plus driver gaps and receiver stalls; generous
   localparam longint unsigned CYCLE_LIMIT = 1500000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   i2c_timing_from_clock_tree_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   req_type pending_reqs[$];   // requests not yet offered
   rsp_type expected_timing[$];   // predicted responses, oldest first
   int      error_count = 0;
   bit      stim_done = 1'b0;
   longint unsigned cycle_count = 0;

   // ---------------------------------------------------------------
   // Timing predictor: clock tree down to APB1, then the I2C fields.
   // ---------------------------------------------------------------
   function automatic rsp_type predict_timing(req_type r);
      rsp_type     t;
      logic [31:0] sys, src, vco, pclk, ahb, apb;
      logic [5:0]  m;
      logic [3:0]  acode;
      logic [2:0]  pcode;
      logic [63:0] k;
      logic        fast;
      m = r.pll_cfg_word[5:0];
      case (r.clock_cfg_word[3:2])
         SEL_HSI: sys = HSI_HZ;
         SEL_HSE: sys = HSE_HZ;
         default: begin
            src = r.pll_cfg_word[22] ? HSE_HZ : HSI_HZ;
            if (m == 0) begin
               sys = 0;
            end else begin
               // product wraps at 32 bits before the P divide
               vco = (src / m) * r.pll_cfg_word[14:6];
               case (r.pll_cfg_word[17:16])
                  2'd0: sys = vco / 2;
                  2'd1: sys = vco / 4;
                  2'd2: sys = vco / 6;
                  default: sys = vco / 8;
               endcase
            end
         end
      endcase
      acode = r.clock_cfg_word[7:4];
      case (acode)
         4'd8: ahb = 2;    4'd9: ahb = 4;    4'd10: ahb = 8;   4'd11: ahb = 16;
         4'd12: ahb = 64;  4'd13: ahb = 128; 4'd14: ahb = 256; 4'd15: ahb = 512;
         default: ahb = 1;
      endcase
      pcode = r.clock_cfg_word[12:10];
      apb = (pcode < 4) ? 32'd1 : (32'd2 << (pcode - 4));
      pclk = (sys / ahb) / apb;
      fast = r.bus_speed_hz > SM_LIMIT_HZ;
      t.pclk1_hz = pclk;
      t.freq_field_mhz = 6'((pclk / 32'd1000000) & 32'h3F);
      t.rise_time_value = 6'(pclk / (fast ? FM_RISE_FREQ : SM_RISE_FREQ) + 1);
      if (r.bus_speed_hz == 0) begin
         t.ccr_divider = '0;
      end else begin
         k = !fast ? 64'd2 : (r.duty_16_9 ? 64'd25 : 64'd3);
         t.ccr_divider = 12'(64'(pclk) / (k * 64'(r.bus_speed_hz)));
      end
      t.fast_mode = fast;
      t.calc_error = (m == 0) || (r.bus_speed_hz == 0);
      return t;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %0d expected %0d at cycle %0d",
               what, got, want, cycle_count);
      error_count++;
   endtask

   function automatic req_type make_req(logic [31:0] c, logic [31:0] p,
                                        logic [19:0] s, logic d);
      req_type r;
      r.clock_cfg_word = c;
      r.pll_cfg_word = p;
      r.bus_speed_hz = s;
      r.duty_16_9 = d;
      return r;
   endfunction

   // PLL setting: M, N, P code, source bit
   function automatic logic [31:0] pll_word(logic [5:0] m, logic [8:0] n,
                                            logic [1:0] p, logic hse,
                                            logic [31:0] junk);
      logic [31:0] w;
      w = junk;
      w[5:0] = m;
      w[14:6] = n;
      w[17:16] = p;
      w[22] = hse;
      return w;
   endfunction

   function automatic logic [31:0] clk_word(logic [1:0] sel, logic [3:0] ahb,
                                            logic [2:0] apb, logic [31:0] junk);
      logic [31:0] w;
      w = junk;
      w[3:2] = sel;
      w[7:4] = ahb;
      w[12:10] = apb;
      return w;
   endfunction

   function automatic logic [19:0] rand_speed();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0: return 20'd0;
         1: return 20'd100000;
         2: return 20'd100001;
         3: return 20'd1000000;
         4: return 20'($urandom_range(1, 100000));
         5: return 20'($urandom);      // any 20-bit value, beyond 1 MHz too
         default: return 20'($urandom_range(1, 1000000));
      endcase
   endfunction

   // ---------------------------------------------------------------
   // Stimulus: directed corners, then random requests.
   // ---------------------------------------------------------------
   initial begin
      logic [1:0] sel;
      logic [5:0] m;
      // fixed sources, prescaler extremes, all speed classes
      pending_reqs.push_back(make_req(clk_word(SEL_HSI, 4'd0, 3'd0, 0),
                                      32'd1, 20'd100000, 1'b0));
      pending_reqs.push_back(make_req(clk_word(SEL_HSE, 4'd0, 3'd0, 0),
                                      32'd1, 20'd400000, 1'b0));
      pending_reqs.push_back(make_req(clk_word(SEL_HSE, 4'd0, 3'd0, 0),
                                      32'd1, 20'd400000, 1'b1));
      pending_reqs.push_back(make_req(clk_word(SEL_HSI, 4'd15, 3'd7, 0),
                                      32'd8, 20'd1, 1'b0));
      pending_reqs.push_back(make_req(clk_word(SEL_HSI, 4'd14, 3'd4, 0),
                                      32'd8, 20'd100001, 1'b1));
      // zero bus speed and zero M with a fixed source
      pending_reqs.push_back(make_req(clk_word(SEL_HSI, 4'd0, 3'd0, 0),
                                      32'd8, 20'd0, 1'b1));
      pending_reqs.push_back(make_req(clk_word(SEL_HSE, 4'd8, 3'd5, 0),
                                      32'd0, 20'd100000, 1'b0));
      // PLL: typical 168 MHz, zero M, wide product wrap, both sel codes
      pending_reqs.push_back(make_req(clk_word(SEL_PLL_A, 4'd0, 3'd5, 0),
                                      pll_word(6'd8, 9'd336, 2'd0, 1'b1, 0),
                                      20'd400000, 1'b1));
      pending_reqs.push_back(make_req(clk_word(SEL_PLL_B, 4'd0, 3'd0, 0),
                                      pll_word(6'd0, 9'd336, 2'd0, 1'b1, 0),
                                      20'd100000, 1'b0));
      pending_reqs.push_back(make_req(clk_word(SEL_PLL_A, 4'd0, 3'd0, 0),
                                      pll_word(6'd1, 9'd511, 2'd0, 1'b0, 0),
                                      20'd1000000, 1'b0));
      pending_reqs.push_back(make_req(clk_word(SEL_PLL_B, 4'd0, 3'd0, 32'hFFFF_FFFF),
                                      pll_word(6'd63, 9'd0, 2'd3, 1'b0, 32'hFFFF_FFFF),
                                      20'hFFFFF, 1'b1));
      pending_reqs.push_back(make_req(clk_word(SEL_PLL_A, 4'd15, 3'd7, 0),
                                      pll_word(6'd1, 9'd300, 2'd2, 1'b1, 0),
                                      20'd1, 1'b1));
      pending_reqs.push_back(make_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'd1000000, 1'b0));
      pending_reqs.push_back(make_req(32'h0, 32'h0, 20'd0, 1'b0));
      for (int i = 0; i < N_RANDOM; i++) begin
         sel = 2'($urandom);
         // mostly valid M, sometimes zero
         m = ($urandom_range(0, 9) == 0) ? 6'd0 : 6'($urandom_range(1, 63));
         if ($urandom_range(0, 7) == 0)
            pending_reqs.push_back(make_req($urandom, $urandom, rand_speed(),
                                            1'($urandom)));
         else
            pending_reqs.push_back(make_req(
               clk_word(sel, 4'($urandom), 3'($urandom), $urandom),
               pll_word(m, 9'($urandom), 2'($urandom), 1'($urandom), $urandom),
               rand_speed(), 1'($urandom)));
      end
      stim_done = 1'b1;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // ---------------------------------------------------------------
   // Driver: bursts of requests with random gaps; valid holds until taken.
   // ---------------------------------------------------------------
   int unsigned burst_left = 0;
   int unsigned gap_left = 0;
   int unsigned offered = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_timing.push_back(predict_timing(req_data));
            offered++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               req_data <= pending_reqs.pop_front();
               req_valid <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 12);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 200);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Receiver: own stall pattern, plus one long hold-off to back up the block.
   // ---------------------------------------------------------------
   int unsigned stall_mode = 0;
   int unsigned mode_left = 0;
   int unsigned hold_off = 0;
   bit          hold_done = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off--;
         rsp_ready <= 1'b0;
      end else if (!hold_done && offered == 40) begin
         hold_done = 1'b1;
         hold_off = 3000;    // several requests' worth; front must stall
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 400);
         end
         mode_left--;
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom);
            2: rsp_ready <= ($urandom_range(0, 7) == 0);
            default: rsp_ready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Monitor: compare each response with the oldest prediction.
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_timing.size() == 0) begin
            $display("UNEXPECTED response at cycle %0d", cycle_count);
            error_count++;
         end else begin
            want = expected_timing.pop_front();
            if (rsp_data.pclk1_hz !== want.pclk1_hz)
               report_mismatch("pclk1_hz", rsp_data.pclk1_hz, want.pclk1_hz);
            if (rsp_data.freq_field_mhz !== want.freq_field_mhz)
               report_mismatch("freq_field_mhz", rsp_data.freq_field_mhz,
                               want.freq_field_mhz);
            if (rsp_data.rise_time_value !== want.rise_time_value)
               report_mismatch("rise_time_value", rsp_data.rise_time_value,
                               want.rise_time_value);
            if (rsp_data.ccr_divider !== want.ccr_divider)
               report_mismatch("ccr_divider", rsp_data.ccr_divider, want.ccr_divider);
            if (rsp_data.fast_mode !== want.fast_mode)
               report_mismatch("fast_mode", rsp_data.fast_mode, want.fast_mode);
            if (rsp_data.calc_error !== want.calc_error)
               report_mismatch("calc_error", rsp_data.calc_error, want.calc_error);
         end
      end
   end

   // ---------------------------------------------------------------
   // End of run: drain, short settle, verdict; or timeout.
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout at cycle %0d", cycle_count);
         $display("i2c_timing_from_clock_tree_top_test NOT OK");
         $finish;
      end
   end

   initial begin
      wait (stim_done);
      @(posedge clock);
      while (pending_reqs.size() > 0 || req_valid || expected_timing.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
      if (error_count == 0) begin
         $display("i2c_timing_from_clock_tree_top_test OK");
      end else begin
         $display("i2c_timing_from_clock_tree_top_test NOT OK");
      end
      $finish;
   end

endmodule
`default_nettype wire
